[sv/dsu_pkg.sv]
package dsu_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned DenW  = 16;
    localparam int unsigned RemW  = 17;
    localparam int unsigned NumCells = DataW;

    localparam logic [1:0] OP_UDIV = 2'd0;
    localparam logic [1:0] OP_SDIV = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    // what the output stage puts out for a word
    localparam logic [1:0] KIND_CALC    = 2'd0;
    localparam logic [1:0] KIND_ONES    = 2'd1;
    localparam logic [1:0] KIND_POS_MAX = 2'd2;
    localparam logic [1:0] KIND_ZERO    = 2'd3;

    localparam logic [DataW-1:0] ALL_ONES = {DataW{1'b1}};
    localparam logic [DataW-1:0] POS_MAX  = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] NEG_MIN  = {1'b1, {(DataW-1){1'b0}}};

    typedef struct packed {
        logic              vld;
        logic              is_root;
        logic              neg;
        logic [1:0]        kind;
        logic [DataW-1:0]  num;
        logic [DenW-1:0]   den;
        logic [RemW-1:0]   rem;
        logic [DataW-1:0]  acc;
    } t_cell;

endpackage

[sv/divide_and_sqrt_unit.sv]
// Pipelined divide / square-root unit. Takes one word per cycle while o_ready is high and
// returns one 32-bit result per word, through one decode stage, a chain of 32 cells
// that each produce one quotient bit (one root bit in every second cell for the square
// root), and an output register. Op 0 is an unsigned 32/16 divide (all ones on a zero
// divisor), op 1 a signed divide truncating toward zero (largest positive value on a
// zero divisor or on minimum / -1), op 2 the floor square root of the operand read as
// signed (0 for zero or negative), op 3 returns 0. A stalled output stalls the whole
// chain; o_ready drops only while a result waits and i_ready is low.
module divide_and_sqrt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_operand,
    input  logic [15:0] i_divisor,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result
);

    logic                           adv;
    dsu_pkg::t_cell                 n_head;
    dsu_pkg::t_cell                 r_head;
    dsu_pkg::t_cell                 chain [dsu_pkg::NumCells+1];
    logic                           r_out_vld;
    logic [dsu_pkg::DataW-1:0]      r_out;
    logic [dsu_pkg::DataW-1:0]      n_out;
    dsu_pkg::t_cell                 tail;

    assign adv     = !(r_out_vld && !i_ready);
    assign o_ready = adv;

    always_comb begin
        n_head         = '0;
        n_head.vld     = i_valid;
        n_head.num     = i_operand;
        n_head.den     = i_divisor;
        n_head.kind    = dsu_pkg::KIND_CALC;
        unique case (i_op)
            dsu_pkg::OP_UDIV: begin
                if (i_divisor == '0) n_head.kind = dsu_pkg::KIND_ONES;
            end
            dsu_pkg::OP_SDIV: begin
                n_head.neg = i_operand[31] ^ i_divisor[15];
                n_head.num = i_operand[31] ? (~i_operand + 32'd1) : i_operand;
                n_head.den = i_divisor[15] ? (~i_divisor + 16'd1) : i_divisor;
                if (i_divisor == '0 ||
                    (i_operand == dsu_pkg::NEG_MIN && i_divisor == 16'hFFFF)) begin
                    n_head.kind = dsu_pkg::KIND_POS_MAX;
                end
            end
            dsu_pkg::OP_SQRT: begin
                n_head.is_root = 1'b1;
                if (i_operand[31] || i_operand == '0) n_head.kind = dsu_pkg::KIND_ZERO;
            end
            default: begin
                n_head.kind = dsu_pkg::KIND_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else if (adv) begin
            r_head.vld <= n_head.vld;
        end
        if (adv) begin
            r_head.is_root <= n_head.is_root;
            r_head.neg     <= n_head.neg;
            r_head.kind    <= n_head.kind;
            r_head.num     <= n_head.num;
            r_head.den     <= n_head.den;
            r_head.rem     <= n_head.rem;
            r_head.acc     <= n_head.acc;
        end
    end

    assign chain[0] = r_head;

    for (genvar g = 0; g < dsu_pkg::NumCells; g++) begin : g_cell
        dsu_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (adv),
            .i_root_step (1'(g % 2)),
            .i_d         (chain[g]),
            .o_q         (chain[g+1])
        );
    end

    assign tail = chain[dsu_pkg::NumCells];

    always_comb begin
        unique case (tail.kind)
            dsu_pkg::KIND_CALC:    n_out = tail.neg ? (~tail.acc + 32'd1) : tail.acc;
            dsu_pkg::KIND_ONES:    n_out = dsu_pkg::ALL_ONES;
            dsu_pkg::KIND_POS_MAX: n_out = dsu_pkg::POS_MAX;
            dsu_pkg::KIND_ZERO:    n_out = '0;
            default:               n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= tail.vld;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

[sv/dsu_cell.sv]
module dsu_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_root_step,
    input  dsu_pkg::t_cell  i_d,
    output dsu_pkg::t_cell  o_q
);

    dsu_pkg::t_cell r_q;
    dsu_pkg::t_cell n_q;

    logic [dsu_pkg::RemW-1:0]   div_sh;
    logic [dsu_pkg::RemW-1:0]   div_diff;
    logic                       div_ge;
    logic [dsu_pkg::RemW+1:0]   rt_sh;
    logic [dsu_pkg::RemW+1:0]   rt_trial;
    logic [dsu_pkg::RemW+1:0]   rt_diff;
    logic                       rt_ge;

    always_comb begin
        div_sh   = {i_d.rem[dsu_pkg::RemW-2:0], i_d.num[dsu_pkg::DataW-1]};
        div_ge   = div_sh >= {1'b0, i_d.den};
        div_diff = div_sh - {1'b0, i_d.den};

        // root digit: bring down two bits, try (2*root)*2 + 1
        rt_sh    = {i_d.rem, i_d.num[dsu_pkg::DataW-1 -: 2]};
        rt_trial = {1'b0, i_d.acc[dsu_pkg::DenW-1:0], 2'b01};
        rt_ge    = rt_sh >= rt_trial;
        rt_diff  = rt_sh - rt_trial;

        n_q = i_d;
        if (!i_d.is_root) begin
            n_q.num = {i_d.num[dsu_pkg::DataW-2:0], 1'b0};
            n_q.rem = div_ge ? div_diff : div_sh;
            n_q.acc = {i_d.acc[dsu_pkg::DataW-2:0], div_ge};
        end else if (i_root_step) begin
            n_q.num = {i_d.num[dsu_pkg::DataW-3:0], 2'b00};
            // remainder stays at most twice the root, so it fits
            n_q.rem = rt_ge ? rt_diff[dsu_pkg::RemW-1:0] : rt_sh[dsu_pkg::RemW-1:0];
            n_q.acc = {i_d.acc[dsu_pkg::DataW-2:0], rt_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q.vld <= n_q.vld;
        end
        if (i_en) begin
            r_q.is_root <= n_q.is_root;
            r_q.neg     <= n_q.neg;
            r_q.kind    <= n_q.kind;
            r_q.num     <= n_q.num;
            r_q.den     <= n_q.den;
            r_q.rem     <= n_q.rem;
            r_q.acc     <= n_q.acc;
        end
    end

    assign o_q = r_q;

endmodule

[bench/result_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the divide / square-root unit, predicts every word taken in
// and compares each word handed out, in order, against the oldest prediction.
module result_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_op,
    input  logic [dsu_pkg::DataW-1:0] i_operand,
    input  logic [dsu_pkg::DenW-1:0]  i_divisor,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [dsu_pkg::DataW-1:0] i_result,
    output int                        o_fail_count,
    output int                        o_words_pending
);

    typedef struct {
        logic [1:0]                op;
        logic [dsu_pkg::DataW-1:0] operand;
        logic [dsu_pkg::DenW-1:0]  divisor;
        logic [dsu_pkg::DataW-1:0] result;
    } t_result_word;

    t_result_word pending_results[$];
    t_result_word taken_word;
    t_result_word oldest_word;

    function automatic logic [dsu_pkg::DataW-1:0] compute_result(
        input logic [1:0]                op,
        input logic [dsu_pkg::DataW-1:0] operand,
        input logic [dsu_pkg::DenW-1:0]  divisor);
        longint num;
        longint den;
        longint quo;
        longint pos_limit;
        longint arg;
        longint root;
        longint trial;
        compute_result = '0;
        case (op)
            dsu_pkg::OP_UDIV: begin
                if (divisor == '0)
                    compute_result = dsu_pkg::ALL_ONES;
                else
                    compute_result = operand /
                        {{(dsu_pkg::DataW - dsu_pkg::DenW){1'b0}}, divisor};
            end
            dsu_pkg::OP_SDIV: begin
                num       = longint'($signed(operand));
                den       = longint'($signed(divisor));
                pos_limit = longint'(dsu_pkg::POS_MAX);
                if (den == 0) begin
                    compute_result = dsu_pkg::POS_MAX;
                end else begin
                    // truncating divide; only min / -1 exceeds the positive range
                    quo = num / den;
                    if (quo > pos_limit)
                        compute_result = dsu_pkg::POS_MAX;
                    else
                        compute_result = quo[dsu_pkg::DataW-1:0];
                end
            end
            dsu_pkg::OP_SQRT: begin
                if (!operand[dsu_pkg::DataW-1] && operand != '0) begin
                    arg  = longint'(operand);
                    root = 0;
                    for (int b = 15; b >= 0; b--) begin
                        trial = root + (longint'(1) << b);
                        if (trial * trial <= arg)
                            root = trial;
                    end
                    compute_result = root[dsu_pkg::DataW-1:0];
                end
            end
            default: compute_result = '0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("word %h with nothing expected", i_result));
                end else begin
                    oldest_word = pending_results.pop_front();
                    if (i_result !== oldest_word.result)
                        report_mismatch($sformatf(
                            "op %0d operand %h divisor %h: result %h, expected %h",
                            oldest_word.op, oldest_word.operand, oldest_word.divisor,
                            i_result, oldest_word.result));
                end
            end
            if (i_in_valid && i_in_ready) begin
                taken_word.op      = i_op;
                taken_word.operand = i_operand;
                taken_word.divisor = i_divisor;
                taken_word.result  = compute_result(i_op, i_operand, i_divisor);
                pending_results.push_back(taken_word);
            end
        end
        o_words_pending = pending_results.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int          RandomWords   = 500;
    localparam int          ResetCycles   = 10;
    localparam int          DrainCycles   = 40;   // extra margin after the last result
    localparam int          WatchdogLimit = 2000;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    // receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_CHOKED   = 3;

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      i_valid   = 1'b0;
    logic [1:0]                i_op      = dsu_pkg::OP_UDIV;
    logic [dsu_pkg::DataW-1:0] i_operand = '0;
    logic [dsu_pkg::DenW-1:0]  i_divisor = '0;
    logic                      i_ready   = 1'b1;
    logic                      o_ready;
    logic                      o_valid;
    logic [dsu_pkg::DataW-1:0] o_result;

    int fail_count;
    int words_pending;
    int burst_left   = 0;
    int rx_mode      = RX_FREE;
    int rx_mode_left = 0;
    int rx_phase     = 0;
    int idle_cycles  = 0;

    always #5 i_clk = ~i_clk;

    divide_and_sqrt_unit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_operand (i_operand),
        .i_divisor (i_divisor),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );

    result_checker check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_op            (i_op),
        .i_operand       (i_operand),
        .i_divisor       (i_divisor),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_result        (o_result),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [1:0] op,
                             input logic [dsu_pkg::DataW-1:0] operand,
                             input logic [dsu_pkg::DenW-1:0] divisor);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45)
                                              : $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_op      <= op;
        i_operand <= operand;
        i_divisor <= divisor;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [dsu_pkg::DataW-1:0] pick_operand(input logic [1:0] op);
        int root;
        pick_operand = $urandom();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 5))
                    0: pick_operand = '0;
                    1: pick_operand = 32'd1;
                    2: pick_operand = dsu_pkg::POS_MAX;
                    3: pick_operand = dsu_pkg::NEG_MIN;
                    4: pick_operand = dsu_pkg::ALL_ONES;
                    default: pick_operand = dsu_pkg::NEG_MIN + 32'd1;
                endcase
            end
            1: pick_operand = $urandom_range(0, 1000);
            2: begin
                // around perfect squares for the root, anywhere for the divides
                if (op == dsu_pkg::OP_SQRT) begin
                    root = $urandom_range(0, 46340);
                    pick_operand = root * root + $urandom_range(0, 2) - 1;
                end
            end
            3: pick_operand = -$urandom_range(1, 1000);
            default: pick_operand = $urandom();
        endcase
    endfunction

    function automatic logic [dsu_pkg::DenW-1:0] pick_divisor();
        pick_divisor = 16'($urandom());
        case ($urandom_range(0, 7))
            0: pick_divisor = '0;
            1: begin
                case ($urandom_range(0, 5))
                    0: pick_divisor = 16'h0001;
                    1: pick_divisor = 16'hFFFF;
                    2: pick_divisor = 16'h8000;
                    3: pick_divisor = 16'h7FFF;
                    4: pick_divisor = 16'hFFFE;
                    default: pick_divisor = 16'h0002;
                endcase
            end
            2: pick_divisor = 16'($urandom_range(1, 20));
            3: pick_divisor = 16'(-$urandom_range(1, 20));
            default: pick_divisor = 16'($urandom());
        endcase
    endfunction

    // receiver: picks a new stall pattern whenever the current one runs out
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(RX_FREE, RX_CHOKED);
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            RX_FREE:     i_ready <= 1'b1;
            RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_ready <= (rx_phase % 8) < 5;
            default:     i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("[%0t] watchdog: no word moved for %0d cycles",
                         $realtime, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0]                op;
        logic [dsu_pkg::DataW-1:0] operand;
        logic [dsu_pkg::DenW-1:0]  divisor;
        int                        n;

        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        send_word(dsu_pkg::OP_UDIV, dsu_pkg::ALL_ONES, 16'h0000);   // divide by zero
        send_word(dsu_pkg::OP_UDIV, dsu_pkg::ALL_ONES, 16'h0001);
        send_word(dsu_pkg::OP_UDIV, dsu_pkg::ALL_ONES, 16'hFFFF);
        send_word(dsu_pkg::OP_UDIV, 32'd0, 16'd5);
        send_word(dsu_pkg::OP_UDIV, 32'd12345678, 16'h8000);
        send_word(dsu_pkg::OP_UDIV, dsu_pkg::NEG_MIN, 16'h7FFF);
        send_word(dsu_pkg::OP_SDIV, 32'd1234, 16'h0000);           // signed divide by zero
        send_word(dsu_pkg::OP_SDIV, dsu_pkg::NEG_MIN, 16'hFFFF);    // min / -1 saturates
        send_word(dsu_pkg::OP_SDIV, dsu_pkg::NEG_MIN, 16'h0001);
        send_word(dsu_pkg::OP_SDIV, dsu_pkg::NEG_MIN, 16'h8000);
        send_word(dsu_pkg::OP_SDIV, dsu_pkg::POS_MAX, 16'hFFFF);
        send_word(dsu_pkg::OP_SDIV, dsu_pkg::POS_MAX, 16'h8000);
        send_word(dsu_pkg::OP_SDIV, -32'sd7, 16'd2);               // truncates toward zero
        send_word(dsu_pkg::OP_SDIV, 32'd7, 16'hFFFE);
        send_word(dsu_pkg::OP_SQRT, 32'd0, 16'h0000);
        send_word(dsu_pkg::OP_SQRT, dsu_pkg::ALL_ONES, 16'hFFFF);   // negative argument
        send_word(dsu_pkg::OP_SQRT, dsu_pkg::NEG_MIN, 16'h0000);
        send_word(dsu_pkg::OP_SQRT, 32'd1, 16'h0000);
        send_word(dsu_pkg::OP_SQRT, 32'd15, 16'h0000);
        send_word(dsu_pkg::OP_SQRT, 32'd2147395600, 16'h0000);     // 46340 squared
        send_word(dsu_pkg::OP_SQRT, 32'd2147395599, 16'h0000);
        send_word(dsu_pkg::OP_SQRT, dsu_pkg::POS_MAX, 16'h0000);
        send_word(OP_UNUSED, dsu_pkg::ALL_ONES, 16'hFFFF);

        for (int i = 0; i < RandomWords; i++) begin
            n = $urandom_range(0, 99);
            if (n < 35)
                op = dsu_pkg::OP_UDIV;
            else if (n < 70)
                op = dsu_pkg::OP_SDIV;
            else if (n < 97)
                op = dsu_pkg::OP_SQRT;
            else
                op = OP_UNUSED;
            operand = pick_operand(op);
            divisor = pick_divisor();
            if (op == dsu_pkg::OP_SDIV && $urandom_range(0, 19) == 0) begin
                operand = dsu_pkg::NEG_MIN;
                divisor = 16'hFFFF;
            end
            send_word(op, operand, divisor);
        end
        i_valid <= 1'b0;

        while (words_pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
